### src/ppbd_pkg.sv
// shared types and constants for the pulse period byte deframer
`default_nettype none
package ppbd_pkg;

	// byte stuffing codes
	localparam logic [7:0] FLAG_BYTE = 8'h7e;
	localparam logic [7:0] ESC_BYTE  = 8'h7d;
	localparam logic [7:0] ESC_XOR   = 8'h20;

	// header id codes in frame byte 1
	localparam logic [7:0] ID_CURRENT    = 8'h28;
	localparam logic [7:0] ID_VOLTS_WHOLE = 8'h3A;
	localparam logic [7:0] ID_VOLTS_FRAC = 8'h3B;
	localparam logic [7:0] ID_CELL       = 8'h06;

	// frame byte 0 at or above this marks the frame as ignored
	localparam logic [7:0] CELL_COUNT_LIMIT = 8'd7;

	// bytes of a frame that are kept
	localparam int HEAD_BYTES = 4;

	// configuration port
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ERROR_WIDTH_LIMIT = 2'd0,
		CFG_DATA_PERIOD_MIN   = 2'd1,
		CFG_DATA_PERIOD_END   = 2'd2,
		CFG_SYNC_PERIOD_MAX   = 2'd3
	} cfg_reg_t;

	localparam logic [CFG_W-1:0] RST_ERROR_WIDTH_LIMIT = 16'd900;
	localparam logic [CFG_W-1:0] RST_DATA_PERIOD_MIN   = 16'd5000;
	localparam logic [CFG_W-1:0] RST_DATA_PERIOD_END   = 16'd7050;
	localparam logic [CFG_W-1:0] RST_SYNC_PERIOD_MAX   = 16'd4000;

	// result kinds
	typedef enum logic [2:0] {
		KIND_CURRENT    = 3'd0,
		KIND_VOLTS_WHOLE = 3'd1,
		KIND_VOLTS_FRAC = 3'd2,
		KIND_CELL       = 3'd3,
		KIND_IGNORED    = 3'd4
	} kind_t;

	// volts scaling: (whole*100 + frac*10)*21/110 == floor(21*s/11), s = 10*whole + frac
	localparam int VSUM_W  = 20;
	localparam int SCALE_W = 24;
	localparam int RECIP_W = 25;
	localparam int RECIP_SHIFT = 28;
	// ceil(2^28 / 11), exact for every 24-bit dividend
	localparam logic [RECIP_W-1:0] RECIP_11 = 25'd24403224;
	localparam int VOLTS_W = 21;
	localparam logic [VOLTS_W-1:0] VOLTS_MAX = 21'd1376235;

	// closed frame handed from the deframer to the decode pipeline
	typedef struct packed {
		kind_t             kind;
		logic [15:0]       word;
		logic [7:0]        cells;
		logic [VSUM_W-1:0] vsum;
	} frame_t;

endpackage
`default_nettype wire

### src/ppbd_deframer.sv
// byte recovery, stuffed-frame state machine and header decode
`default_nettype none
module ppbd_deframer #(
	parameter int FRAME_LIMIT = 19
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                step,
	input  wire logic                period_edge,
	input  wire logic [15:0]         period_ticks,
	input  wire logic [15:0]         high_ticks,
	input  wire logic [15:0]         error_width_limit,
	input  wire logic [15:0]         data_period_min,
	input  wire logic [15:0]         data_period_end,
	input  wire logic [15:0]         sync_period_max,
	output logic                     close,
	output ppbd_pkg::frame_t         frame
);

	localparam int CNT_W = $clog2(FRAME_LIMIT + 1);

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_START = 2'd1,
		PH_FRAME = 2'd2,
		PH_ESC   = 2'd3
	} phase_t;

	phase_t           phase_q, phase_d;
	logic             armed_q, armed_d;
	logic [CNT_W-1:0] cnt_q, cnt_d, cnt_eff;
	logic [7:0]       head_q [ppbd_pkg::HEAD_BYTES];
	logic [7:0]       head_d [ppbd_pkg::HEAD_BYTES];
	logic [15:0]      vw_q, vw_d;

	logic        abort, in_win, armed_eff, closing, store;
	logic [15:0] diff;
	logic [7:0]  data, store_val;
	logic [15:0] word;
	ppbd_pkg::kind_t kind;

	always_comb begin
		abort     = high_ticks > error_width_limit;
		in_win    = (period_ticks >= data_period_min) && (period_ticks < data_period_end);
		diff      = period_ticks - data_period_min;
		data      = diff[10:3];
		armed_eff = armed_q && !abort;
		cnt_eff   = abort ? '0 : cnt_q;

		armed_d   = armed_eff;
		cnt_d     = cnt_eff;
		phase_d   = phase_q;
		head_d    = head_q;
		closing   = 1'b0;
		store     = 1'b0;
		store_val = data;

		if (period_edge && in_win && armed_eff) begin
			unique case (phase_q)
				PH_START: begin
					if (data != ppbd_pkg::FLAG_BYTE) begin
						store   = 1'b1;
						phase_d = PH_FRAME;
					end
				end
				PH_FRAME: begin
					if (data == ppbd_pkg::ESC_BYTE) begin
						phase_d = PH_ESC;
					end else if (data == ppbd_pkg::FLAG_BYTE) begin
						closing = 1'b1;
						phase_d = PH_IDLE;
					end else begin
						store = 1'b1;
					end
				end
				PH_ESC: begin
					store     = 1'b1;
					store_val = data ^ ppbd_pkg::ESC_XOR;
					phase_d   = PH_FRAME;
				end
				PH_IDLE: begin
					if (data == ppbd_pkg::FLAG_BYTE) begin
						cnt_d   = '0;
						phase_d = PH_START;
					end
				end
			endcase
		end else if (period_ticks < sync_period_max) begin
			armed_d = 1'b1;
			cnt_d   = '0;
		end

		// bytes past the limit are dropped, only the head is kept
		if (store && (cnt_eff < CNT_W'(FRAME_LIMIT))) begin
			if (cnt_eff < CNT_W'(ppbd_pkg::HEAD_BYTES))
				head_d[cnt_eff[1:0]] = store_val;
			cnt_d = cnt_eff + 1'b1;
		end
	end

	// header decode on the bytes stored so far
	always_comb begin
		word = {head_q[3], head_q[2]};
		kind = ppbd_pkg::KIND_IGNORED;
		if (head_q[0] < ppbd_pkg::CELL_COUNT_LIMIT) begin
			unique case (head_q[1])
				ppbd_pkg::ID_CURRENT:     kind = ppbd_pkg::KIND_CURRENT;
				ppbd_pkg::ID_VOLTS_WHOLE: kind = ppbd_pkg::KIND_VOLTS_WHOLE;
				ppbd_pkg::ID_VOLTS_FRAC:  kind = ppbd_pkg::KIND_VOLTS_FRAC;
				ppbd_pkg::ID_CELL:        kind = ppbd_pkg::KIND_CELL;
				default:                  kind = ppbd_pkg::KIND_IGNORED;
			endcase
		end
		vw_d = (closing && kind == ppbd_pkg::KIND_VOLTS_WHOLE) ? word : vw_q;

		close       = step && closing;
		frame.kind  = kind;
		frame.word  = word;
		frame.cells = head_q[0];
		frame.vsum  = (ppbd_pkg::VSUM_W'(vw_q) << 3) + (ppbd_pkg::VSUM_W'(vw_q) << 1)
			+ ppbd_pkg::VSUM_W'(word);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			armed_q <= 1'b0;
			cnt_q   <= '0;
			vw_q    <= '0;
			for (int i = 0; i < ppbd_pkg::HEAD_BYTES; i++)
				head_q[i] <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			armed_q <= armed_d;
			cnt_q   <= cnt_d;
			vw_q    <= vw_d;
			head_q  <= head_d;
		end
	end

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(FRAME_LIMIT))
		else $error("byte count beyond frame limit");

	a_start_empty: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_START |-> cnt_q == '0)
		else $error("bytes counted before first frame byte");

	a_close_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		close |-> (phase_q == PH_FRAME) && armed_q && step)
		else $error("frame closed outside frame phase");
`endif

endmodule
`default_nettype wire

### src/ppbd_decode.sv
// result pipeline: volts scaling by reciprocal multiply and output register
`default_nettype none
module ppbd_decode (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              take,
	input  wire ppbd_pkg::frame_t  frame,
	output logic                   ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [2:0]             frame_kind,
	output logic [15:0]            sensor_word,
	output logic [20:0]            volts_tenths,
	output logic [3:0]             cell_index,
	output logic [2:0]             cell_count,
	output logic [12:0]            cell_millivolts
);

	localparam int PROD_W = ppbd_pkg::SCALE_W + ppbd_pkg::RECIP_W;

	logic                          v2_q, v3_q, vo_q;
	logic                          rdy2, rdy3, rdyo;
	ppbd_pkg::frame_t              fr_s2;
	ppbd_pkg::kind_t               kind_s3;
	logic [15:0]                   word_s3;
	logic [7:0]                    cells_s3;
	logic [ppbd_pkg::SCALE_W-1:0]  x_s3, x_d;
	logic [PROD_W-1:0]             prod;
	logic [ppbd_pkg::VOLTS_W-1:0]  quot;

	logic [2:0]  kind_q;
	logic [15:0] word_q;
	logic [20:0] volts_q;
	logic [3:0]  idx_q;
	logic [2:0]  cnt_q;
	logic [12:0] mv_q;

	always_comb begin
		rdyo  = !vo_q || out_ready;
		rdy3  = !v3_q || rdyo;
		rdy2  = !v2_q || rdy3;
		ready = rdy2;
		// 21*s as shifts and adds
		x_d   = (ppbd_pkg::SCALE_W'(fr_s2.vsum) << 4) + (ppbd_pkg::SCALE_W'(fr_s2.vsum) << 2)
			+ ppbd_pkg::SCALE_W'(fr_s2.vsum);
		prod  = PROD_W'(x_s3) * PROD_W'(ppbd_pkg::RECIP_11);
		quot  = prod[ppbd_pkg::RECIP_SHIFT +: ppbd_pkg::VOLTS_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			vo_q <= 1'b0;
		end else begin
			if (rdy2)
				v2_q <= take;
			if (rdy3)
				v3_q <= v2_q;
			if (rdyo)
				vo_q <= v3_q;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && take)
			fr_s2 <= frame;
		if (rdy3 && v2_q) begin
			kind_s3  <= fr_s2.kind;
			word_s3  <= fr_s2.word;
			cells_s3 <= fr_s2.cells;
			x_s3     <= x_d;
		end
		if (rdyo && v3_q) begin
			kind_q  <= kind_s3;
			word_q  <= (kind_s3 == ppbd_pkg::KIND_IGNORED) ? 16'd0 : word_s3;
			volts_q <= (kind_s3 == ppbd_pkg::KIND_VOLTS_FRAC) ? quot : 21'd0;
			if (kind_s3 == ppbd_pkg::KIND_CELL) begin
				idx_q <= word_s3[15:12];
				cnt_q <= cells_s3[2:0];
				mv_q  <= {word_s3[11:0], 1'b0};
			end else begin
				idx_q <= '0;
				cnt_q <= '0;
				mv_q  <= '0;
			end
		end
	end

	assign out_valid       = vo_q;
	assign frame_kind      = kind_q;
	assign sensor_word     = word_q;
	assign volts_tenths    = volts_q;
	assign cell_index      = idx_q;
	assign cell_count      = cnt_q;
	assign cell_millivolts = mv_q;

`ifndef SYNTH
	a_volts_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_kind == ppbd_pkg::KIND_VOLTS_FRAC |-> volts_tenths <= ppbd_pkg::VOLTS_MAX)
		else $error("volts result out of range");

	a_ignored_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_kind == ppbd_pkg::KIND_IGNORED |-> sensor_word == 16'd0
			&& volts_tenths == 21'd0 && cell_millivolts == 13'd0)
		else $error("ignored frame carries data");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(frame_kind)
			&& $stable(sensor_word) && $stable(volts_tenths) && $stable(cell_millivolts))
		else $error("result beat changed while stalled");
`endif

endmodule
`default_nettype wire

### src/pulse_period_byte_deframer_core.sv
// top level: input register, configuration registers, deframer and result pipeline
// path: a closing flag beat passes the input, frame, scale and output registers in turn
// throughput: one input beat per cycle unless stalled; results leave through a three-stage
//   pipeline (register, 21x scale, reciprocal multiply) that stalls stage by stage
// reset: arst_n clears receiver state, header bytes, stored volts and valid flags,
//   and loads the configuration defaults
`default_nettype none
module pulse_period_byte_deframer_core #(
	parameter int FRAME_LIMIT = 19
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// capture beats
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        period_edge,
	input  wire logic [15:0] period_ticks,
	input  wire logic [15:0] high_ticks,
	// result beats
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       frame_kind,
	output logic [15:0]      sensor_word,
	output logic [20:0]      volts_tenths,
	output logic [3:0]       cell_index,
	output logic [2:0]       cell_count,
	output logic [12:0]      cell_millivolts,
	// register writes
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [ppbd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [ppbd_pkg::CFG_W-1:0]     cfg_data
);

	// configuration registers
	logic [15:0] err_width_q, per_min_q, per_end_q, sync_max_q;

	// input register
	logic        v1_q;
	logic        edge_s1;
	logic [15:0] period_s1, high_s1;

	logic             fire1, pipe_ready, close;
	ppbd_pkg::frame_t frame;

	// writes are always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_width_q <= ppbd_pkg::RST_ERROR_WIDTH_LIMIT;
			per_min_q   <= ppbd_pkg::RST_DATA_PERIOD_MIN;
			per_end_q   <= ppbd_pkg::RST_DATA_PERIOD_END;
			sync_max_q  <= ppbd_pkg::RST_SYNC_PERIOD_MAX;
		end else if (cfg_valid) begin
			unique case (ppbd_pkg::cfg_reg_t'(cfg_index))
				ppbd_pkg::CFG_ERROR_WIDTH_LIMIT: err_width_q <= cfg_data;
				ppbd_pkg::CFG_DATA_PERIOD_MIN:   per_min_q   <= cfg_data;
				ppbd_pkg::CFG_DATA_PERIOD_END:   per_end_q   <= cfg_data;
				ppbd_pkg::CFG_SYNC_PERIOD_MAX:   sync_max_q  <= cfg_data;
			endcase
		end
	end

	// the beat in the input register is consumed once the result pipeline can take
	// a closed frame; most beats close nothing and just update the deframer state
	assign fire1    = v1_q && pipe_ready;
	assign in_ready = !v1_q || fire1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v1_q <= 1'b0;
		else if (in_ready)
			v1_q <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			edge_s1   <= period_edge;
			period_s1 <= period_ticks;
			high_s1   <= high_ticks;
		end
	end

	// byte recovery and frame state, updated once per consumed beat
	ppbd_deframer #(
		.FRAME_LIMIT(FRAME_LIMIT)
	) u_deframer (
		.clk               (clk),
		.arst_n            (arst_n),
		.step              (fire1),
		.period_edge       (edge_s1),
		.period_ticks      (period_s1),
		.high_ticks        (high_s1),
		.error_width_limit (err_width_q),
		.data_period_min   (per_min_q),
		.data_period_end   (per_end_q),
		.sync_period_max   (sync_max_q),
		.close             (close),
		.frame             (frame)
	);

	// scaling and result register
	ppbd_decode u_decode (
		.clk             (clk),
		.arst_n          (arst_n),
		.take            (close),
		.frame           (frame),
		.ready           (pipe_ready),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.frame_kind      (frame_kind),
		.sensor_word     (sensor_word),
		.volts_tenths    (volts_tenths),
		.cell_index      (cell_index),
		.cell_count      (cell_count),
		.cell_millivolts (cell_millivolts)
	);

endmodule
`default_nettype wire
